// File: design/dsrm_pkg.sv
// dsrm_pkg: shared sizes, payload structs, command and state types
// for the domain suffix rule matcher; no dependencies
package dsrm_pkg;

  localparam int RULE_SLOTS = 16;
  localparam int MAX_DOMAIN = 256;

  localparam int RIDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int POS_W  = $clog2(MAX_DOMAIN);
  localparam int TOK_W  = $clog2(MAX_DOMAIN + 1);
  localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_LIST   = 2'd1;
  localparam logic [1:0] REQ_DOMAIN = 2'd2;

  localparam logic RESULT_LIST    = 1'b0;
  localparam logic RESULT_VERDICT = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       matched;
    logic [6:0] rules_held;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LIST,
    OP_DOMAIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fifo_rd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN,
    BK_RD,
    BK_CMP,
    BK_OUT
  } bk_state_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

// File: design/domain_suffix_rule_matcher_unit.sv
// a rule list or clear beat is handled by the back end in its idle state; a domain
// end beat walks the rules with a length check state per rule and a read and a
// compare state per compared character, then the verdict state; the back end
// sequencer takes one character per cycle outside verdicts and result slot stalls
// reset: synchronous active low rst_n empties the queue and the rule table and
// clears the parser and domain length; memories hold stale data, never read unwritten
module domain_suffix_rule_matcher_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsrm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsrm_pkg::out_item_t out_data
);

  logic               fifo_full, push, pop;
  dsrm_pkg::cmd_t     push_cmd;
  dsrm_pkg::fifo_rd_t rd;

  dsrm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dsrm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .rd       (rd)
  );

  dsrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/dsrm_front.sv
// dsrm_front: accepts input beats, classifies the request and folds rule text
// depends on dsrm_pkg
module dsrm_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  dsrm_pkg::in_item_t in_data,
  input  logic               fifo_full,
  output logic               push,
  output dsrm_pkg::cmd_t     push_cmd
);

  logic known;

  always_comb begin
    known         = 1'b1;
    push_cmd.op   = dsrm_pkg::OP_CLEAR;
    push_cmd.ch   = in_data.char_byte;
    push_cmd.last = in_data.is_last;
    unique case (in_data.req_type)
      dsrm_pkg::REQ_CLEAR:  push_cmd.op = dsrm_pkg::OP_CLEAR;
      dsrm_pkg::REQ_LIST: begin
        push_cmd.op = dsrm_pkg::OP_LIST;
        push_cmd.ch = dsrm_pkg::fold_lower(in_data.char_byte);
      end
      dsrm_pkg::REQ_DOMAIN: push_cmd.op = dsrm_pkg::OP_DOMAIN;
      default:              known = 1'b0;
    endcase
  end

  // unused request codes are taken and dropped
  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full && known;

endmodule

// File: design/dsrm_fifo.sv
// dsrm_fifo: short command queue between front and back
// depends on dsrm_pkg
module dsrm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dsrm_pkg::cmd_t     push_cmd,
  output logic               full,
  input  logic               pop,
  output dsrm_pkg::fifo_rd_t rd
);

  dsrm_pkg::cmd_t                   slot_r [dsrm_pkg::FIFO_DEPTH];
  logic [dsrm_pkg::FIFO_AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [dsrm_pkg::FIFO_AW:0]       cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (dsrm_pkg::FIFO_AW+1)'(push) - (dsrm_pkg::FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  assign full     = (cnt_r == (dsrm_pkg::FIFO_AW+1)'(dsrm_pkg::FIFO_DEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.cmd   = slot_r[rp_r];

endmodule

// File: design/dsrm_back.sv
// dsrm_back: rule list parser, domain window and suffix compare sequencer,
// with the result register; depends on dsrm_pkg
module dsrm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dsrm_pkg::fifo_rd_t  rd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output dsrm_pkg::out_item_t out_data
);

  localparam int POS_W  = dsrm_pkg::POS_W;
  localparam int TOK_W  = dsrm_pkg::TOK_W;
  localparam int CNT_W  = dsrm_pkg::CNT_W;
  localparam int RIDX_W = dsrm_pkg::RIDX_W;

  logic [7:0]       rule_mem [dsrm_pkg::RULE_SLOTS][dsrm_pkg::MAX_DOMAIN];
  logic [7:0]       dom_mem  [dsrm_pkg::MAX_DOMAIN];
  logic [POS_W-1:0] rule_len_r [dsrm_pkg::RULE_SLOTS];

  dsrm_pkg::bk_state_t st_r, st_nxt;
  logic [CNT_W-1:0]  tot_r, tot_nxt;
  logic [TOK_W-1:0]  tok_r, tok_nxt;
  logic              in_tok_r, in_tok_nxt;
  logic [POS_W-1:0]  dlen_r, dlen_nxt;
  logic [POS_W-1:0]  wptr_r, wptr_nxt;
  logic [RIDX_W-1:0] ridx_r, ridx_nxt;
  logic [POS_W-1:0]  k_r, k_nxt;
  logic [POS_W-1:0]  rlen_r, rlen_nxt;
  logic [POS_W-1:0]  vlen_r, vlen_nxt;
  logic [POS_W-1:0]  vend_r, vend_nxt;
  logic              match_r, match_nxt;
  logic              out_valid_r, out_valid_nxt;
  dsrm_pkg::out_item_t out_data_r, out_data_nxt;

  logic              slot_free;
  logic              rmem_we, len_we, dmem_we;
  logic [TOK_W-1:0]  base_len, len1, cl_len;
  logic              is_ws, do_char, do_close, cl_go, in_tok1;
  logic [POS_W-1:0]  dl1, cur_len;
  logic [POS_W-1:0]  rpos, dpos;
  logic [POS_W:0]    dpos_wide;
  logic [7:0]        rule_rd_r, dom_rd_r;
  logic              last_rule;

  assign slot_free = !out_valid_r || out_ready;
  assign last_rule = ((CNT_W'(ridx_r) + 1'b1) == tot_r);
  assign cur_len   = rule_len_r[ridx_r];

  // read positions counted back from the end of the rule and the domain
  always_comb begin
    rpos = rlen_r - k_r;
    if (k_r > vend_r) begin
      dpos_wide = {1'b0, vend_r} + (POS_W+1)'(dsrm_pkg::MAX_DOMAIN) - {1'b0, k_r};
    end else begin
      dpos_wide = {1'b0, vend_r} - {1'b0, k_r};
    end
    dpos = dpos_wide[POS_W-1:0];
  end

  // rule list token parsing
  always_comb begin
    is_ws    = (rd.cmd.ch == dsrm_pkg::CH_SPACE) || (rd.cmd.ch == dsrm_pkg::CH_TAB) ||
               (rd.cmd.ch == dsrm_pkg::CH_COMMA);
    do_char  = 1'b0;
    do_close = 1'b0;
    if (!in_tok_r) begin
      do_char = !is_ws;
    end else if (rd.cmd.ch == dsrm_pkg::CH_COMMA) begin
      do_close = 1'b1;
    end else begin
      do_char = 1'b1;
    end
    base_len = in_tok_r ? tok_r : '0;
    in_tok1  = in_tok_r;
    len1     = tok_r;
    if (do_char) begin
      in_tok1 = 1'b1;
      len1    = (base_len == TOK_W'(dsrm_pkg::MAX_DOMAIN)) ? base_len : base_len + 1'b1;
    end
    cl_len = do_close ? tok_r : len1;
    cl_go  = do_close ? 1'b1 : (rd.cmd.last && in_tok1);
  end

  always_comb begin
    st_nxt        = st_r;
    tot_nxt       = tot_r;
    tok_nxt       = tok_r;
    in_tok_nxt    = in_tok_r;
    dlen_nxt      = dlen_r;
    wptr_nxt      = wptr_r;
    ridx_nxt      = ridx_r;
    k_nxt         = k_r;
    rlen_nxt      = rlen_r;
    vlen_nxt      = vlen_r;
    vend_nxt      = vend_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    rmem_we       = 1'b0;
    len_we        = 1'b0;
    dmem_we       = 1'b0;
    dl1           = (dlen_r == POS_W'(dsrm_pkg::MAX_DOMAIN - 1)) ? dlen_r : dlen_r + 1'b1;
    unique case (st_r)
      dsrm_pkg::BK_IDLE: begin
        if (rd.valid) begin
          unique case (rd.cmd.op)
            dsrm_pkg::OP_CLEAR: begin
              pop        = 1'b1;
              tot_nxt    = '0;
              tok_nxt    = '0;
              in_tok_nxt = 1'b0;
            end
            dsrm_pkg::OP_LIST: begin
              if (!rd.cmd.last || slot_free) begin
                pop     = 1'b1;
                rmem_we = do_char && (tot_r < CNT_W'(dsrm_pkg::RULE_SLOTS)) &&
                          (base_len < TOK_W'(dsrm_pkg::MAX_DOMAIN - 1));
                if (cl_go && (cl_len < TOK_W'(dsrm_pkg::MAX_DOMAIN)) &&
                    (tot_r < CNT_W'(dsrm_pkg::RULE_SLOTS))) begin
                  len_we  = 1'b1;
                  tot_nxt = tot_r + 1'b1;
                end
                if (rd.cmd.last || do_close) begin
                  in_tok_nxt = 1'b0;
                  tok_nxt    = '0;
                end else begin
                  in_tok_nxt = in_tok1;
                  tok_nxt    = len1;
                end
                if (rd.cmd.last) begin
                  out_valid_nxt           = 1'b1;
                  out_data_nxt.result_kind = dsrm_pkg::RESULT_LIST;
                  out_data_nxt.matched    = 1'b0;
                  out_data_nxt.rules_held = 7'(tot_nxt);
                end
              end
            end
            dsrm_pkg::OP_DOMAIN: begin
              pop      = 1'b1;
              dmem_we  = 1'b1;
              wptr_nxt = (wptr_r == POS_W'(dsrm_pkg::MAX_DOMAIN - 1)) ? '0 : wptr_r + 1'b1;
              if (rd.cmd.last) begin
                dlen_nxt = '0;
                vlen_nxt = dl1;
                vend_nxt = wptr_nxt;
                ridx_nxt = '0;
                if (tot_r == '0) begin
                  match_nxt = 1'b1;
                  st_nxt    = dsrm_pkg::BK_OUT;
                end else begin
                  st_nxt = dsrm_pkg::BK_LEN;
                end
              end else begin
                dlen_nxt = dl1;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      dsrm_pkg::BK_LEN: begin
        rlen_nxt = cur_len;
        k_nxt    = POS_W'(1);
        if (cur_len == '0 || cur_len > vlen_r) begin
          if (last_rule) begin
            match_nxt = 1'b0;
            st_nxt    = dsrm_pkg::BK_OUT;
          end else begin
            ridx_nxt = ridx_r + 1'b1;
          end
        end else begin
          st_nxt = dsrm_pkg::BK_RD;
        end
      end
      dsrm_pkg::BK_RD: st_nxt = dsrm_pkg::BK_CMP;
      dsrm_pkg::BK_CMP: begin
        if (rule_rd_r != dom_rd_r) begin
          if (last_rule) begin
            match_nxt = 1'b0;
            st_nxt    = dsrm_pkg::BK_OUT;
          end else begin
            ridx_nxt = ridx_r + 1'b1;
            st_nxt   = dsrm_pkg::BK_LEN;
          end
        end else if (k_r == rlen_r) begin
          match_nxt = 1'b1;
          st_nxt    = dsrm_pkg::BK_OUT;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = dsrm_pkg::BK_RD;
        end
      end
      dsrm_pkg::BK_OUT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_kind = dsrm_pkg::RESULT_VERDICT;
          out_data_nxt.matched     = match_r;
          out_data_nxt.rules_held  = 7'(tot_r);
          st_nxt                   = dsrm_pkg::BK_IDLE;
        end
      end
      default: st_nxt = dsrm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dsrm_pkg::BK_IDLE;
      tot_r       <= '0;
      tok_r       <= '0;
      in_tok_r    <= 1'b0;
      dlen_r      <= '0;
      wptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tot_r       <= tot_nxt;
      tok_r       <= tok_nxt;
      in_tok_r    <= in_tok_nxt;
      dlen_r      <= dlen_nxt;
      wptr_r      <= wptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r     <= ridx_nxt;
    k_r        <= k_nxt;
    rlen_r     <= rlen_nxt;
    vlen_r     <= vlen_nxt;
    vend_r     <= vend_nxt;
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
    if (len_we) begin
      rule_len_r[tot_r[RIDX_W-1:0]] <= cl_len[POS_W-1:0];
    end
  end

  // rule text and domain window memories, one write and one read port each
  always_ff @(posedge clk) begin
    if (rmem_we) begin
      rule_mem[tot_r[RIDX_W-1:0]][base_len[POS_W-1:0]] <= rd.cmd.ch;
    end
    rule_rd_r <= rule_mem[ridx_r][rpos];
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dom_mem[wptr_r] <= rd.cmd.ch;
    end
    dom_rd_r <= dom_mem[dpos];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: verif/tb_domain_suffix_rule_matcher_unit.sv
// testbench for domain_suffix_rule_matcher_unit: a behavioural model of the rule table,
// list parser and suffix verdict predicts each result beat; depends on dsrm_pkg
`timescale 1ns / 100ps

module tb_domain_suffix_rule_matcher_unit;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  dsrm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  dsrm_pkg::out_item_t out_data;

  domain_suffix_rule_matcher_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // table and parser state
  logic [7:0] tbl_text [dsrm_pkg::RULE_SLOTS][dsrm_pkg::MAX_DOMAIN];
  int         tbl_len  [dsrm_pkg::RULE_SLOTS];
  int         tbl_count;
  int         tok_len;
  bit         in_tok;
  logic [7:0] dom_win  [dsrm_pkg::MAX_DOMAIN];
  int         dom_len;

  dsrm_pkg::out_item_t expected_beats[$];
  int                  fail_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void end_token();
    if (in_tok && tok_len < dsrm_pkg::MAX_DOMAIN && tbl_count < dsrm_pkg::RULE_SLOTS) begin
      tbl_len[tbl_count] = tok_len;
      tbl_count++;
    end
    in_tok  = 0;
    tok_len = 0;
  endfunction

  function automatic bit suffix_hit();
    bit ok;
    if (tbl_count == 0) return 1;
    for (int r = 0; r < tbl_count; r++) begin
      if (tbl_len[r] == 0 || tbl_len[r] > dom_len) continue;
      ok = 1;
      for (int k = 0; k < tbl_len[r]; k++)
        if (dom_win[dom_len - tbl_len[r] + k] != tbl_text[r][k]) ok = 0;
      if (ok) return 1;
    end
    return 0;
  endfunction

  function automatic void predict_beat(dsrm_pkg::in_item_t it);
    dsrm_pkg::out_item_t res;
    logic [7:0] c;
    c = it.char_byte;
    case (it.req_type)
      dsrm_pkg::REQ_CLEAR: begin
        tbl_count = 0;
        in_tok    = 0;
        tok_len   = 0;
      end
      dsrm_pkg::REQ_LIST: begin
        if (!in_tok) begin
          if (!(c == dsrm_pkg::CH_SPACE || c == dsrm_pkg::CH_TAB || c == dsrm_pkg::CH_COMMA)) begin
            in_tok  = 1;
            tok_len = 0;
          end
        end else if (c == dsrm_pkg::CH_COMMA) begin
          end_token();
        end
        if (in_tok) begin
          if (tbl_count < dsrm_pkg::RULE_SLOTS && tok_len < dsrm_pkg::MAX_DOMAIN - 1)
            tbl_text[tbl_count][tok_len] = to_lower(c);
          if (tok_len < dsrm_pkg::MAX_DOMAIN) tok_len++;
        end
        if (it.is_last) begin
          end_token();
          res.result_kind = dsrm_pkg::RESULT_LIST;
          res.matched     = 1'b0;
          res.rules_held  = 7'(tbl_count);
          expected_beats.push_back(res);
        end
      end
      dsrm_pkg::REQ_DOMAIN: begin
        if (dom_len < dsrm_pkg::MAX_DOMAIN - 1) begin
          dom_win[dom_len] = c;
          dom_len++;
        end else begin
          for (int k = 0; k < dsrm_pkg::MAX_DOMAIN - 2; k++) dom_win[k] = dom_win[k + 1];
          dom_win[dsrm_pkg::MAX_DOMAIN - 2] = c;
        end
        if (it.is_last) begin
          res.result_kind = dsrm_pkg::RESULT_VERDICT;
          res.matched     = suffix_hit();
          res.rules_held  = 7'(tbl_count);
          dom_len         = 0;
          expected_beats.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // one beat on the input channel; valid drops only while the sender idles
  task automatic send_beat(logic [1:0] rt, logic [7:0] c, logic last);
    dsrm_pkg::in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.req_type  = rt;
    it.char_byte = c;
    it.is_last   = last;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(it);
  endtask

  task automatic send_text(logic [1:0] rt, string s);
    for (int k = 0; k < s.len(); k++) send_beat(rt, s[k], k == s.len() - 1);
  endtask

  task automatic send_clear();
    send_beat(dsrm_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // receiver stalls and result checking
  always @(posedge clk) begin
    dsrm_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.matched !== want.matched ||
              out_data.rules_held !== want.rules_held) begin
            $display("%0t: mismatch, expected kind %0d match %0d rules %0d, actual %0d %0d %0d",
                     $time, want.result_kind, want.matched, want.rules_held,
                     out_data.result_kind, out_data.matched, out_data.rules_held);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic string rand_word(int n, bit upper_mix);
    string s;
    byte ch;
    s = "";
    for (int k = 0; k < n; k++) begin
      ch = byte'(8'h61 + $urandom_range(3));
      if (upper_mix && $urandom_range(1)) ch = ch - 8'sd32;
      s = {s, string'(ch)};
    end
    return s;
  endfunction

  task automatic test_directed();
    send_text(dsrm_pkg::REQ_DOMAIN, "any.org");      // empty table matches
    send_clear();
    send_text(dsrm_pkg::REQ_LIST, " \t,Example.COM, ,b.c,");
    send_text(dsrm_pkg::REQ_DOMAIN, "x.example.com");
    send_text(dsrm_pkg::REQ_DOMAIN, "X.EXAMPLE.COM"); // domain is not folded
    send_text(dsrm_pkg::REQ_DOMAIN, "ab.c");         // raw suffix, no label check
    send_beat(REQ_UNUSED, 8'hff, 1'b1);
    send_beat(dsrm_pkg::REQ_LIST, 8'h00, 1'b1);      // zero byte token
    send_beat(dsrm_pkg::REQ_DOMAIN, 8'h00, 1'b1);
    send_beat(dsrm_pkg::REQ_LIST, 8'h80, 1'b0);      // token abandoned by clear
    send_clear();
    send_beat(dsrm_pkg::REQ_LIST, dsrm_pkg::CH_COMMA, 1'b1);
    send_beat(dsrm_pkg::REQ_DOMAIN, 8'h7f, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_tokens();
    byte ch;
    send_clear();
    // shortest dropped token, its text partly overwritten by the next one
    for (int k = 0; k < dsrm_pkg::MAX_DOMAIN; k++) send_beat(dsrm_pkg::REQ_LIST, "z", 1'b0);
    send_text(dsrm_pkg::REQ_LIST, ",qqq");
    // long domain saturates the window
    for (int k = 0; k < 257; k++) send_beat(dsrm_pkg::REQ_DOMAIN, "q", k == 256);
    send_text(dsrm_pkg::REQ_DOMAIN, "qq");
    send_clear();
    for (int k = 0; k < dsrm_pkg::RULE_SLOTS + 2; k++) begin // table full
      ch = byte'(8'h61 + k);
      send_text(dsrm_pkg::REQ_LIST, {string'(ch), ","});
    end
    send_beat(dsrm_pkg::REQ_LIST, " ", 1'b1);
    send_text(dsrm_pkg::REQ_DOMAIN, "xp");
    send_text(dsrm_pkg::REQ_DOMAIN, "xq");
    wait_drained();
  endtask

  task automatic test_random(int items);
    int sent;
    string w;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: begin send_clear(); sent++; end
        1, 2: begin
          w = "";
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(3) == 0) w = {w, " "};
            w = {w, rand_word($urandom_range(1, 4), 1'b1), ","};
          end
          send_text(dsrm_pkg::REQ_LIST, w);
          sent += w.len();
        end
        3: begin
          send_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end
        default: begin
          w = rand_word($urandom_range(1, 8), $urandom_range(3) == 0);
          send_text(dsrm_pkg::REQ_DOMAIN, w);
          sent += w.len();
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tbl_count = 0;
    tok_len = 0;
    in_tok = 0;
    dom_len = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_tokens();
    test_random(15);
    send_idle_pct = 54;
    test_random(15);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    test_random(15);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    test_random(15);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
design/dsrm_pkg.sv
design/dsrm_front.sv
design/dsrm_fifo.sv
design/dsrm_back.sv
design/domain_suffix_rule_matcher_unit.sv
verif/tb_domain_suffix_rule_matcher_unit.sv
